@@ rtl/nep_pkg.sv @@
// shared types and constants for the entry table bundle parser
package nep_pkg;

    // segment byte that marks a movable segment
    localparam logic [7:0] SEG_MOVABLE  = 8'hFF;

    // entry lengths in bytes
    localparam logic [2:0] STRIDE_SHORT = 3'd3;
    localparam logic [2:0] STRIDE_LONG  = 3'd6;

    // one result beat as produced by the parse step
    typedef struct packed {
        logic        valid;
        logic [7:0]  segment_number;
        logic [15:0] entry_offset;
        logic [7:0]  repeat_count;
    } nep_res_t;

endpackage

@@ rtl/ne_entry_table_bundle_parser_top.sv @@
// top level of the entry table bundle parser: input register, parse step, result register
//
//  channel | signals                                         | direction
//  --------+-------------------------------------------------+----------
//  in      | in_valid, in_stall, data_byte, final_byte       | sink
//  out     | out_valid, out_stall, segment_number,           | source
//          | entry_offset, repeat_count                      |
//
// one byte per cycle unless a result waits on a stalled output; a byte's result is loaded
// into the result register after the byte is taken, through the input register and the parse step.
// rst_n clears both stage valids and the parse state (expect count byte,
// position zero).
// a stalled result holds; a byte that produces no result still moves on
// while a stalled result holds the result register, one that produces a result waits.
module ne_entry_table_bundle_parser_top
    import nep_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        final_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  segment_number,
    output logic [15:0] entry_offset,
    output logic [7:0]  repeat_count
);

    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;
    logic        s1_final_reg;
    logic        out_valid_reg;
    logic [7:0]  seg_out_reg;
    logic [15:0] off_out_reg;
    logic [7:0]  cnt_out_reg;

    logic        out_free;
    logic        advance;
    logic        in_take;
    nep_res_t    res;

    // stage control
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = s1_valid_reg && (!res.valid || out_free);
    assign in_stall = s1_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg  <= data_byte;
            s1_final_reg <= final_byte;
        end
    end

    // parse step
    nep_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .data_byte  (s1_byte_reg),
        .final_byte (s1_final_reg),
        .res        (res)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && res.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res.valid)
        begin
            seg_out_reg <= res.segment_number;
            off_out_reg <= res.entry_offset;
            cnt_out_reg <= res.repeat_count;
        end
    end

    assign out_valid      = out_valid_reg;
    assign segment_number = seg_out_reg;
    assign entry_offset   = off_out_reg;
    assign repeat_count   = cnt_out_reg;

    // a result never overwrites a beat still waiting downstream
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall && advance) |-> !res.valid)
        else $error("result written over a stalled beat");

    // every reported entry or bundle carries a nonzero count
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res.valid) |-> (res.repeat_count != 8'd0))
        else $error("result with zero repeat count");

    // real entries are reported one at a time
    a_entry_single: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res.valid && (res.segment_number != 8'd0)) |-> (res.repeat_count == 8'd1))
        else $error("entry result with count other than one");

    // a result from the parse step lands in the output register
    a_result_has_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res.valid) |=> out_valid_reg)
        else $error("result lost on its way to the output register");

endmodule

@@ rtl/nep_parse.sv @@
// parse state and one-byte step logic of the entry table bundle parser
module nep_parse
    import nep_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] data_byte,
    input  logic       final_byte,
    output nep_res_t   res
);

    typedef enum logic [1:0] {
        PH_COUNT,
        PH_SEGMENT,
        PH_ENTRIES,
        PH_DONE
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  left_reg, left_next;
    logic [2:0]  bie_reg, bie_next;
    logic [2:0]  stride_reg, stride_next;
    logic [7:0]  seg_reg, seg_next;
    logic [15:0] pos_reg, pos_next;

    logic [2:0]  bie_inc;
    logic [7:0]  left_dec;

    assign bie_inc  = bie_reg + 3'd1;
    assign left_dec = left_reg - 8'd1;

    // next state and result for the byte in the input register
    always_comb
    begin
        phase_next  = phase_reg;
        left_next   = left_reg;
        bie_next    = bie_reg;
        stride_next = stride_reg;
        seg_next    = seg_reg;
        pos_next    = pos_reg + 16'd1;

        res.valid          = 1'b0;
        res.segment_number = seg_reg;
        res.entry_offset   = pos_reg;
        res.repeat_count   = 8'd1;

        case (phase_reg)
            PH_COUNT:
            begin
                if (data_byte == 8'd0)
                begin
                    phase_next = PH_DONE;
                end
                else
                begin
                    left_next  = data_byte;
                    phase_next = PH_SEGMENT;
                end
            end
            PH_SEGMENT:
            begin
                seg_next = data_byte;
                if (!final_byte)
                begin
                    if (data_byte == 8'd0)
                    begin
                        // empty bundle reported once with its count
                        res.valid          = 1'b1;
                        res.segment_number = 8'd0;
                        res.entry_offset   = pos_reg + 16'd1;
                        res.repeat_count   = left_reg;
                        left_next          = 8'd0;
                        phase_next         = PH_COUNT;
                    end
                    else
                    begin
                        stride_next = (data_byte == SEG_MOVABLE) ? STRIDE_LONG : STRIDE_SHORT;
                        bie_next    = 3'd0;
                        phase_next  = PH_ENTRIES;
                    end
                end
            end
            PH_ENTRIES:
            begin
                if (bie_reg == 3'd0)
                begin
                    res.valid = 1'b1;
                end
                if (bie_inc >= stride_reg)
                begin
                    bie_next  = 3'd0;
                    left_next = left_dec;
                    if (left_dec == 8'd0)
                    begin
                        phase_next = PH_COUNT;
                    end
                end
                else
                begin
                    bie_next = bie_inc;
                end
            end
            default:
            begin
            end
        endcase

        // rearm after the last byte of the table
        if (final_byte)
        begin
            phase_next  = PH_COUNT;
            left_next   = 8'd0;
            bie_next    = 3'd0;
            stride_next = 3'd0;
            seg_next    = 8'd0;
            pos_next    = 16'd0;
        end
    end

    // parse state, updated once per byte that leaves the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_COUNT;
            left_reg   <= 8'd0;
            bie_reg    <= 3'd0;
            stride_reg <= 3'd0;
            seg_reg    <= 8'd0;
            pos_reg    <= 16'd0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            left_reg   <= left_next;
            bie_reg    <= bie_next;
            stride_reg <= stride_next;
            seg_reg    <= seg_next;
            pos_reg    <= pos_next;
        end
    end

endmodule

@@ dv/ne_entry_table_bundle_parser_top_tb.sv @@
// testbench for the entry table bundle parser: directed and random tables checked against a predictor
module ne_entry_table_bundle_parser_top_tb;
    import nep_pkg::*;

    localparam logic [7:0] SEG_EMPTY    = 8'h00;
    localparam logic [7:0] SEG_CONSTANT = 8'hFE;
    localparam logic [7:0] COUNT_END    = 8'h00;
    localparam int unsigned TAIL_CALM   = 150;
    localparam int unsigned QUIET_LIMIT = 1000;
    localparam int unsigned DRAIN_CYCLES = 12;
    localparam int unsigned DIR_ROWS    = 24;
    localparam int unsigned ITEM_TARGET = 940;

    typedef enum logic [1:0] {WAIT_COUNT, WAIT_SEGMENT, IN_ENTRIES, SKIP_TO_END} scan_state_t;

    typedef struct packed {
        logic [7:0]  segment;
        logic [15:0] offset;
        logic [7:0]  repeats;
    } report_t;

    // one table byte; typed rows carry a hand-written expected report
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       typed;
        report_t    want;
    } table_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'h00;
    logic        final_byte = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  segment_number;
    logic [15:0] entry_offset;
    logic [7:0]  repeat_count;

    table_beat_t table_beats[$];
    report_t     reports_due[$];
    int unsigned send_ptr = 0;
    int unsigned send_gap = 0;
    int unsigned stall_left = 0;
    int unsigned quiet_cycles = 0;
    int unsigned fail_count = 0;

    // predictor state
    scan_state_t scan_state = WAIT_COUNT;
    logic [7:0]  entries_due = 8'h00;
    logic [2:0]  entry_byte = 3'd0;
    logic [2:0]  entry_len = 3'd0;
    logic [7:0]  cur_segment = 8'h00;
    logic [15:0] table_pos = 16'h0000;

    // directed tables: two-entry constant bundle, empty bundle, truncated movable entry,
    // zero count with trailing bytes, final on count byte, final on empty segment byte,
    // result on the final byte, final zero count
    table_beat_t directed_rows [DIR_ROWS] = '{
        '{8'h02,         1'b0, 1'b0, '{8'h00, 16'h0000, 8'h00}},
        '{SEG_CONSTANT,  1'b0, 1'b0, '{8'h00, 16'h0000, 8'h00}},
        '{8'h00,         1'b0, 1'b1, '{SEG_CONSTANT, 16'd2, 8'd1}},
        '{8'hFF,         1'b0, 1'b0, '{8'h00, 16'h0000, 8'h00}},
        '{8'h80,         1'b0, 1'b0, '{8'h00, 16'h0000, 8'h00}},
        '{8'h01,         1'b0, 1'b1, '{SEG_CONSTANT, 16'd5, 8'd1}},
        '{8'h7F,         1'b0, 1'b0, '{8'h00, 16'h0000, 8'h00}},
        '{8'h00,         1'b0, 1'b0, '{8'h00, 16'h0000, 8'h00}},
        '{8'hFF,         1'b0, 1'b0, '{8'h00, 16'h0000, 8'h00}},
        '{SEG_EMPTY,     1'b0, 1'b1, '{SEG_EMPTY, 16'd10, 8'hFF}},
        '{8'h01,         1'b0, 1'b0, '{8'h00, 16'h0000, 8'h00}},
        '{SEG_MOVABLE,   1'b0, 1'b0, '{8'h00, 16'h0000, 8'h00}},
        '{8'h12,         1'b0, 1'b1, '{SEG_MOVABLE, 16'd12, 8'd1}},
        '{8'h34,         1'b1, 1'b0, '{8'h00, 16'h0000, 8'h00}},
        '{COUNT_END,     1'b0, 1'b0, '{8'h00, 16'h0000, 8'h00}},
        '{8'hAA,         1'b0, 1'b0, '{8'h00, 16'h0000, 8'h00}},
        '{8'h55,         1'b1, 1'b0, '{8'h00, 16'h0000, 8'h00}},
        '{8'h03,         1'b1, 1'b0, '{8'h00, 16'h0000, 8'h00}},
        '{8'h07,         1'b0, 1'b0, '{8'h00, 16'h0000, 8'h00}},
        '{SEG_EMPTY,     1'b1, 1'b0, '{8'h00, 16'h0000, 8'h00}},
        '{8'h01,         1'b0, 1'b0, '{8'h00, 16'h0000, 8'h00}},
        '{8'h01,         1'b0, 1'b0, '{8'h00, 16'h0000, 8'h00}},
        '{8'hC3,         1'b1, 1'b1, '{8'h01, 16'd2, 8'd1}},
        '{COUNT_END,     1'b1, 1'b0, '{8'h00, 16'h0000, 8'h00}}
    };

    // clock
    initial
    begin
        forever #4 clk = ~clk;
    end

    ne_entry_table_bundle_parser_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .final_byte     (final_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .segment_number (segment_number),
        .entry_offset   (entry_offset),
        .repeat_count   (repeat_count)
    );

    // advance the parse state by one table byte; returns 1 when a report is due
    function automatic logic predict_report(input logic [7:0] b, input logic last,
                                            output report_t rec);
        logic [15:0] pos;
        logic        hit;
        pos = table_pos;
        hit = 1'b0;
        rec = '0;
        case (scan_state)
            WAIT_COUNT:
            begin
                if (b == COUNT_END)
                    scan_state = SKIP_TO_END;
                else
                begin
                    entries_due = b;
                    scan_state = WAIT_SEGMENT;
                end
            end
            WAIT_SEGMENT:
            begin
                cur_segment = b;
                if (!last)
                begin
                    if (b == SEG_EMPTY)
                    begin
                        rec = '{SEG_EMPTY, pos + 16'd1, entries_due};
                        hit = 1'b1;
                        entries_due = 8'h00;
                        scan_state = WAIT_COUNT;
                    end
                    else
                    begin
                        entry_len = (b == SEG_MOVABLE) ? STRIDE_LONG : STRIDE_SHORT;
                        entry_byte = 3'd0;
                        scan_state = IN_ENTRIES;
                    end
                end
            end
            IN_ENTRIES:
            begin
                if (entry_byte == 3'd0)
                begin
                    rec = '{cur_segment, pos, 8'd1};
                    hit = 1'b1;
                end
                entry_byte = entry_byte + 3'd1;
                if (entry_byte >= entry_len)
                begin
                    entry_byte = 3'd0;
                    entries_due = entries_due - 8'd1;
                    if (entries_due == 8'h00)
                        scan_state = WAIT_COUNT;
                end
            end
            default:
            begin
            end
        endcase
        table_pos = pos + 16'd1;
        // the final byte rearms the parser for a new table
        if (last)
        begin
            scan_state = WAIT_COUNT;
            entries_due = 8'h00;
            entry_byte = 3'd0;
            entry_len = 3'd0;
            cur_segment = 8'h00;
            table_pos = 16'h0000;
        end
        return hit;
    endfunction

    function automatic logic in_tail();
        return send_ptr + TAIL_CALM >= table_beats.size();
    endfunction

    task automatic add_byte(input logic [7:0] b, input logic last);
        table_beat_t beat;
        beat = '0;
        beat.data = b;
        beat.last = last;
        table_beats.push_back(beat);
    endtask

    // count byte, segment byte, then the entry bytes with random content
    task automatic add_bundle(input logic [7:0] cnt, input logic [7:0] seg);
        int unsigned n;
        add_byte(cnt, 1'b0);
        add_byte(seg, 1'b0);
        n = (seg == SEG_EMPTY) ? 0 :
            cnt * ((seg == SEG_MOVABLE) ? int'(STRIDE_LONG) : int'(STRIDE_SHORT));
        repeat (n) add_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    // mostly well-formed tables that end cleanly or get cut at a random byte; some noise
    task automatic add_random_table();
        int unsigned first;
        int unsigned cut;
        logic [7:0]  seg;
        logic [7:0]  cnt;
        first = table_beats.size();
        if ($urandom_range(0, 6) == 0)
        begin
            repeat ($urandom_range(1, 12)) add_byte(8'($urandom_range(0, 255)), 1'b0);
            table_beats[table_beats.size() - 1].last = 1'b1;
        end
        else
        begin
            repeat ($urandom_range(1, 5))
            begin
                case ($urandom_range(0, 3))
                    0: seg = SEG_EMPTY;
                    1: seg = SEG_CONSTANT;
                    2: seg = SEG_MOVABLE;
                    default: seg = 8'($urandom_range(1, 8'hFD));
                endcase
                // large counts only on empty bundles so that tables stay short
                cnt = (seg == SEG_EMPTY && $urandom_range(0, 3) == 0)
                      ? 8'($urandom_range(1, 255)) : 8'($urandom_range(1, 4));
                add_bundle(cnt, seg);
            end
            if ($urandom_range(0, 1) == 0)
            begin
                add_byte(COUNT_END, 1'b0);
                repeat ($urandom_range(0, 3)) add_byte(8'($urandom_range(0, 255)), 1'b0);
                table_beats[table_beats.size() - 1].last = 1'b1;
            end
            else
            begin
                cut = $urandom_range(first, table_beats.size() - 1);
                table_beats[cut].last = 1'b1;
                while (table_beats.size() > cut + 1)
                    void'(table_beats.pop_back());
            end
        end
    endtask

    // input side: present beats, take acceptance, insert idle bursts
    always @(posedge clk or negedge rst_n)
    begin
        report_t rec;
        logic    hit;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            data_byte <= 8'h00;
            final_byte <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                hit = predict_report(data_byte, final_byte, rec);
                if (table_beats[send_ptr].typed)
                    reports_due.push_back(table_beats[send_ptr].want);
                else if (hit)
                    reports_due.push_back(rec);
                send_ptr = send_ptr + 1;
            end
            if (!(in_valid && in_stall))
            begin
                if (send_gap != 0)
                begin
                    in_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (send_ptr < table_beats.size() && !in_tail() &&
                         $urandom_range(0, 4) == 0)
                begin
                    in_valid <= 1'b0;
                    send_gap <= $urandom_range(0, 6);
                end
                else if (send_ptr < table_beats.size())
                begin
                    in_valid <= 1'b1;
                    data_byte <= table_beats[send_ptr].data;
                    final_byte <= table_beats[send_ptr].last;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // output side: random stall bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (stall_left != 0)
        begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (!in_tail() && $urandom_range(0, 5) == 0)
        begin
            out_stall <= 1'b1;
            stall_left <= $urandom_range(0, 6);
        end
        else
            out_stall <= 1'b0;
    end

    // compare each result beat with the oldest expected report
    always @(posedge clk)
    begin
        report_t want;
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (rst_n && out_valid && !out_stall)
        begin
            if (reports_due.size() == 0)
            begin
                $error("unexpected result: segment_number %0h entry_offset %0h repeat_count %0h",
                       segment_number, entry_offset, repeat_count);
                fail_count = fail_count + 1;
            end
            else
            begin
                want = reports_due.pop_front();
                if (segment_number !== want.segment)
                begin
                    $error("segment_number expected %0h actual %0h", want.segment, segment_number);
                    fail_count = fail_count + 1;
                end
                if (entry_offset !== want.offset)
                begin
                    $error("entry_offset expected %0h actual %0h", want.offset, entry_offset);
                    fail_count = fail_count + 1;
                end
                if (repeat_count !== want.repeats)
                begin
                    $error("repeat_count expected %0h actual %0h", want.repeats, repeat_count);
                    fail_count = fail_count + 1;
                end
            end
        end
    end

    // watchdog: too long with no beat moving on either side
    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("ne_entry_table_bundle_parser_top test failed");
        $finish;
    end

    // stimulus build, reset, end of run
    initial
    begin
        for (int i = 0; i < DIR_ROWS; i++)
            table_beats.push_back(directed_rows[i]);
        while (table_beats.size() < ITEM_TARGET)
            add_random_table();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (send_ptr < table_beats.size() || reports_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("ne_entry_table_bundle_parser_top test passed");
        else
            $display("ne_entry_table_bundle_parser_top test failed");
        $finish;
    end

endmodule
